// ----- rtl/ipus_pkg.sv -----
// ipus_pkg: shared constants, types and tables for the iris polar unwrap sampler
// no dependencies; used by every rtl module of the block

package ipus_pkg;

  // frame and sampling grid
  localparam int FRAME_WIDTH  = 512;
  localparam int FRAME_HEIGHT = 512;
  localparam int ANGLE_STEPS  = 256;
  localparam int RADIAL_STEPS = 64;

  localparam int COL_W     = $clog2(FRAME_WIDTH);
  localparam int ROW_W     = $clog2(FRAME_HEIGHT);
  localparam int ADDR_W    = COL_W + ROW_W;
  localparam int ANG_W     = $clog2(ANGLE_STEPS);
  localparam int RAD_SHIFT = $clog2(RADIAL_STEPS);
  localparam int PIX_W     = 8;

  // datapath widths
  localparam int RADIUS_W  = 10;
  localparam int TRIG_W    = 17;
  localparam int TRIG_FRAC = 15;
  localparam int PROD_W    = RADIUS_W + TRIG_W;
  localparam int COORD_W   = 13;
  localparam int MAP_W     = 11;
  localparam int VEC_W     = 34;
  localparam int ANGLE_W   = 33;
  localparam int PHASE_W   = 32;

  // cordic
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam logic signed [VEC_W-1:0]  CORDIC_START = VEC_W'(652032874);
  localparam logic signed [TRIG_W-1:0] ONE_Q15      = TRIG_W'(32768);

  localparam logic [PIX_W-1:0] OUTSIDE_VALUE = 8'hFF;

  // job queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_X     = 4'd0,
    REG_CENTER_Y     = 4'd1,
    REG_PUPIL_RADIUS = 4'd2,
    REG_IRIS_RADIUS  = 4'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    QUAD_I,
    QUAD_II,
    QUAD_III,
    QUAD_IV
  } quad_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_ROUND,
    ST_MULT,
    ST_COORD,
    ST_READ,
    ST_DONE
  } back_state_t;

  typedef struct packed {
    logic                        is_sample;
    logic [ADDR_W-1:0]           addr;
    logic [PIX_W-1:0]            data;
    logic [ANG_W-1:0]            angle;
    logic signed [RADIUS_W-1:0]  radius;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic res_load;
  } back_stat_t;

  // arctangent of 2^-k in units of 2^-32 turn
  function automatic logic signed [ANGLE_W-1:0] atan_step(input logic [STEP_W-1:0] k);
    logic signed [ANGLE_W-1:0] a;
    case (k)
      4'd0:    a = ANGLE_W'(32'h20000000);
      4'd1:    a = ANGLE_W'(32'h12E4051E);
      4'd2:    a = ANGLE_W'(32'h09FB385B);
      4'd3:    a = ANGLE_W'(32'h051111D4);
      4'd4:    a = ANGLE_W'(32'h028B0D43);
      4'd5:    a = ANGLE_W'(32'h0145D7E1);
      4'd6:    a = ANGLE_W'(32'h00A2F61E);
      4'd7:    a = ANGLE_W'(32'h00517C55);
      4'd8:    a = ANGLE_W'(32'h0028BE53);
      4'd9:    a = ANGLE_W'(32'h00145F2F);
      4'd10:   a = ANGLE_W'(32'h000A2F98);
      4'd11:   a = ANGLE_W'(32'h000517CC);
      4'd12:   a = ANGLE_W'(32'h00028BE6);
      4'd13:   a = ANGLE_W'(32'h000145F3);
      4'd14:   a = ANGLE_W'(32'h0000A2FA);
      default: a = ANGLE_W'(32'h0000517D);
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/iris_polar_unwrap_sampler_top.sv -----
// iris polar unwrap sampler: pixel writes one per cycle while the job queue is not full;
// samples run one at a time through the iterative cordic rotation unit and the mapping
// writes and samples are carried out in acceptance order through a 4-entry job queue
// rst (synchronous, active high) empties the queue and result register and zeroes the
// configuration registers; the frame store has no reset and holds garbage until written
// depends on ipus_pkg, ipus_front, ipus_fifo, ipus_back

module iris_polar_unwrap_sampler_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // input queue side
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 opcode,
  input  logic [8:0]                           pixel_col,
  input  logic [8:0]                           pixel_row,
  input  logic [7:0]                           pixel_value,
  input  logic [7:0]                           angle_index,
  input  logic [5:0]                           radial_index,
  // result register side
  output logic                                 empty,
  input  logic                                 pop,
  output logic [7:0]                           sample_value,
  output logic                                 outside_frame,
  output logic signed [10:0]                   mapped_col,
  output logic signed [10:0]                   mapped_row,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ipus_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ipus_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // configuration registers
  logic [8:0] center_x;
  logic [8:0] center_y;
  logic [7:0] pupil_radius;
  logic [7:0] iris_radius;

  // front to queue
  logic                 q_push;
  ipus_pkg::job_t       q_din;
  // queue to back
  ipus_pkg::job_t       q_head;
  ipus_pkg::q_stat_t    q_stat;
  logic                 q_pop;
  ipus_pkg::back_stat_t back_stat;

  // writes are always accepted; unknown indexes fall through
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      pupil_radius <= '0;
      iris_radius  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (ipus_pkg::cfg_reg_t'(cfg_index))
        ipus_pkg::REG_CENTER_X:     center_x     <= cfg_data[8:0];
        ipus_pkg::REG_CENTER_Y:     center_y     <= cfg_data[8:0];
        ipus_pkg::REG_PUPIL_RADIUS: pupil_radius <= cfg_data[7:0];
        ipus_pkg::REG_IRIS_RADIUS:  iris_radius  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // front: classify, drop off-frame writes, compute the sample radius
  ipus_front u_front (
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .pixel_value  (pixel_value),
    .angle_index  (angle_index),
    .radial_index (radial_index),
    .pupil_radius (pupil_radius),
    .iris_radius  (iris_radius),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .job          (q_din)
  );

  // job queue decouples acceptance from execution
  ipus_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_din),
    .pop  (q_pop),
    .head (q_head),
    .stat (q_stat)
  );

  // back: frame store, cordic, coordinate mapping and result register
  ipus_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .center_x      (center_x),
    .center_y      (center_y),
    .pop           (pop),
    .empty         (empty),
    .sample_value  (sample_value),
    .outside_frame (outside_frame),
    .mapped_col    (mapped_col),
    .mapped_row    (mapped_row),
    .stat          (back_stat)
  );

`ifndef SYNTHESIS
  // back never takes a job from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("job queue popped while empty");

  // a new result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    back_stat.res_load |-> (empty || pop))
    else $error("result register overwritten");

  // a job is only taken while the back is idle
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !back_stat.busy)
    else $error("job popped while back busy");

  // reset leaves the job queue and the result register empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && q_stat.empty))
    else $error("queues not empty after reset");
`endif

endmodule

// ----- rtl/ipus_front.sv -----
// ipus_front: accepts input items, drops off-frame writes, forms the job entry
// depends on ipus_pkg (job_t, q_stat_t, frame constants)

module ipus_front (
  input  logic                              push,
  output logic                              full,
  input  logic                              opcode,
  input  logic [8:0]                        pixel_col,
  input  logic [8:0]                        pixel_row,
  input  logic [7:0]                        pixel_value,
  input  logic [7:0]                        angle_index,
  input  logic [5:0]                        radial_index,
  input  logic [7:0]                        pupil_radius,
  input  logic [7:0]                        iris_radius,
  input  ipus_pkg::q_stat_t                 q_stat,
  output logic                              q_push,
  output ipus_pkg::job_t                    job
);

  logic                 is_sample;
  logic                 in_frame;
  logic signed [8:0]    ring_width;
  logic signed [7:0]    step_mul;
  logic signed [16:0]   ring_prod;
  logic signed [16:0]   ring_quot;

  assign is_sample = (ipus_pkg::opcode_t'(opcode) == ipus_pkg::OP_SAMPLE);
  assign in_frame  = (32'(pixel_col) < 32'(ipus_pkg::FRAME_WIDTH)) &&
                     (32'(pixel_row) < 32'(ipus_pkg::FRAME_HEIGHT));

  // radius: pupil + (iris - pupil) * (j + 1) / steps, quotient toward zero
  assign ring_width = $signed({1'b0, iris_radius}) - $signed({1'b0, pupil_radius});
  assign step_mul   = $signed({1'b0, 7'(radial_index) + 7'd1});
  assign ring_prod  = 17'(ring_width) * 17'(step_mul);
  assign ring_quot  = (ring_prod + (ring_prod[16] ? 17'(ipus_pkg::RADIAL_STEPS - 1) : 17'sd0))
                      >>> ipus_pkg::RAD_SHIFT;

  assign full   = q_stat.full;
  assign q_push = push && !q_stat.full && (is_sample || in_frame);

  always_comb begin
    job.is_sample = is_sample;
    job.addr      = {pixel_row[ipus_pkg::ROW_W-1:0], pixel_col[ipus_pkg::COL_W-1:0]};
    job.data      = pixel_value;
    job.angle     = angle_index[ipus_pkg::ANG_W-1:0];
    job.radius    = $signed({2'b00, pupil_radius}) + ring_quot[ipus_pkg::RADIUS_W-1:0];
  end

endmodule

// ----- rtl/ipus_fifo.sv -----
// ipus_fifo: short register queue of job entries between front and back
// depends on ipus_pkg (job_t, q_stat_t, QDEPTH)

module ipus_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ipus_pkg::job_t     din,
  input  logic               pop,
  output ipus_pkg::job_t     head,
  output ipus_pkg::q_stat_t  stat
);

  ipus_pkg::job_t                slots [ipus_pkg::QDEPTH];
  logic [ipus_pkg::QPTR_W-1:0]   wr_ptr;
  logic [ipus_pkg::QPTR_W-1:0]   rd_ptr;
  logic [ipus_pkg::QPTR_W:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (ipus_pkg::QPTR_W+1)'(push) - (ipus_pkg::QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == (ipus_pkg::QPTR_W+1)'(ipus_pkg::QDEPTH));
  assign stat.empty = (count == '0);

endmodule

// ----- rtl/ipus_back.sv -----
// ipus_back: executes jobs - frame store writes, cordic unit vector, mapping, lookup
// depends on ipus_pkg (job_t, back_state_t, atan_step, widths)

module ipus_back (
  input  logic                      clk,
  input  logic                      rst,
  input  ipus_pkg::job_t            head,
  input  ipus_pkg::q_stat_t         q_stat,
  output logic                      q_pop,
  input  logic [8:0]                center_x,
  input  logic [8:0]                center_y,
  input  logic                      pop,
  output logic                      empty,
  output logic [7:0]                sample_value,
  output logic                      outside_frame,
  output logic signed [10:0]        mapped_col,
  output logic signed [10:0]        mapped_row,
  output ipus_pkg::back_stat_t      stat
);

  localparam logic signed [ipus_pkg::VEC_W-1:0] ROUND_HALF =
    ipus_pkg::VEC_W'(1 << (ipus_pkg::TRIG_FRAC - 1));
  localparam logic signed [ipus_pkg::VEC_W-1:0] ONE_WIDE =
    ipus_pkg::VEC_W'(1 << ipus_pkg::TRIG_FRAC);
  localparam logic signed [ipus_pkg::COORD_W-1:0] MAP_MAX =
    ipus_pkg::COORD_W'((1 << (ipus_pkg::MAP_W - 1)) - 1);
  localparam logic signed [ipus_pkg::COORD_W-1:0] MAP_MIN =
    ipus_pkg::COORD_W'(-(1 << (ipus_pkg::MAP_W - 1)));

  function automatic logic signed [ipus_pkg::TRIG_W-1:0] round_q15(
    input logic signed [ipus_pkg::VEC_W-1:0] v
  );
    logic signed [ipus_pkg::VEC_W-1:0] rv;
    logic signed [ipus_pkg::TRIG_W-1:0] res;
    rv = (v + ROUND_HALF) >>> ipus_pkg::TRIG_FRAC;
    if (rv < 0) res = '0;
    else if (rv > ONE_WIDE) res = ipus_pkg::ONE_Q15;
    else res = rv[ipus_pkg::TRIG_W-1:0];
    return res;
  endfunction

  function automatic logic signed [ipus_pkg::MAP_W-1:0] sat_map(
    input logic signed [ipus_pkg::COORD_W-1:0] v
  );
    logic signed [ipus_pkg::COORD_W-1:0] c;
    if (v > MAP_MAX) c = MAP_MAX;
    else if (v < MAP_MIN) c = MAP_MIN;
    else c = v;
    return c[ipus_pkg::MAP_W-1:0];
  endfunction

  ipus_pkg::back_state_t state, state_next;

  logic mem_we, mem_re, load_job, res_load, out_valid;

  logic [ipus_pkg::PIX_W-1:0]          frame_store [ipus_pkg::FRAME_WIDTH*ipus_pkg::FRAME_HEIGHT];
  logic [ipus_pkg::PIX_W-1:0]          rd_data;
  logic [ipus_pkg::ADDR_W-1:0]         rd_addr;

  logic [ipus_pkg::PHASE_W-1:0]        phase;
  logic [ipus_pkg::STEP_W-1:0]         step;
  logic signed [ipus_pkg::VEC_W-1:0]   vx, vy, dx, dy;
  logic signed [ipus_pkg::ANGLE_W-1:0] vz;
  ipus_pkg::quad_t                     quad;
  logic                                zero_angle;
  logic signed [ipus_pkg::RADIUS_W-1:0] radius;
  logic signed [ipus_pkg::TRIG_W-1:0]  c_mag, s_mag, cs, sn;
  logic signed [ipus_pkg::PROD_W-1:0]  prod_x, prod_y;
  logic signed [ipus_pkg::COORD_W-1:0] px, py;
  logic                                outside;

  assign phase = {head.angle, {(ipus_pkg::PHASE_W - ipus_pkg::ANG_W){1'b0}}};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipus_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    load_job   = 1'b0;
    res_load   = 1'b0;
    case (state)
      ipus_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (head.is_sample) begin
            load_job   = 1'b1;
            state_next = ipus_pkg::ST_ROTATE;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      ipus_pkg::ST_ROTATE: begin
        if (step == ipus_pkg::STEP_W'(ipus_pkg::CORDIC_STEPS - 1)) begin
          state_next = ipus_pkg::ST_ROUND;
        end
      end
      ipus_pkg::ST_ROUND: state_next = ipus_pkg::ST_MULT;
      ipus_pkg::ST_MULT:  state_next = ipus_pkg::ST_COORD;
      ipus_pkg::ST_COORD: state_next = ipus_pkg::ST_READ;
      ipus_pkg::ST_READ: begin
        mem_re     = 1'b1;
        state_next = ipus_pkg::ST_DONE;
      end
      ipus_pkg::ST_DONE: begin
        if (!out_valid || pop) begin
          res_load   = 1'b1;
          state_next = ipus_pkg::ST_IDLE;
        end
      end
      default: state_next = ipus_pkg::ST_IDLE;
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (load_job) begin
      step <= '0;
    end else if (state == ipus_pkg::ST_ROTATE) begin
      step <= step + 1'b1;
    end
  end

  // one cordic micro-rotation per cycle
  assign dx = vy >>> step;
  assign dy = vx >>> step;

  assign c_mag = zero_angle ? ipus_pkg::ONE_Q15 : round_q15(vx);
  assign s_mag = zero_angle ? '0 : round_q15(vy);

  always_ff @(posedge clk) begin
    if (load_job) begin
      vx         <= ipus_pkg::CORDIC_START;
      vy         <= '0;
      vz         <= $signed({3'b000, phase[ipus_pkg::PHASE_W-3:0]});
      quad       <= ipus_pkg::quad_t'(phase[ipus_pkg::PHASE_W-1:ipus_pkg::PHASE_W-2]);
      zero_angle <= (phase[ipus_pkg::PHASE_W-3:0] == '0);
      radius     <= head.radius;
    end else if (state == ipus_pkg::ST_ROTATE) begin
      if (!vz[ipus_pkg::ANGLE_W-1]) begin
        vx <= vx - dx;
        vy <= vy + dy;
        vz <= vz - ipus_pkg::atan_step(step);
      end else begin
        vx <= vx + dx;
        vy <= vy - dy;
        vz <= vz + ipus_pkg::atan_step(step);
      end
    end
    if (state == ipus_pkg::ST_ROUND) begin
      case (quad)
        ipus_pkg::QUAD_I:   begin cs <= c_mag;  sn <= s_mag;  end
        ipus_pkg::QUAD_II:  begin cs <= -s_mag; sn <= c_mag;  end
        ipus_pkg::QUAD_III: begin cs <= -c_mag; sn <= -s_mag; end
        default:            begin cs <= s_mag;  sn <= -c_mag; end
      endcase
    end
    if (state == ipus_pkg::ST_MULT) begin
      prod_x <= ipus_pkg::PROD_W'(radius) * ipus_pkg::PROD_W'(cs);
      prod_y <= ipus_pkg::PROD_W'(radius) * ipus_pkg::PROD_W'(sn);
    end
    if (state == ipus_pkg::ST_COORD) begin
      px <= $signed(ipus_pkg::COORD_W'(center_x)) +
            ipus_pkg::COORD_W'(prod_x >>> ipus_pkg::TRIG_FRAC);
      py <= $signed(ipus_pkg::COORD_W'(center_y)) +
            ipus_pkg::COORD_W'(prod_y >>> ipus_pkg::TRIG_FRAC);
    end
  end

  assign outside = px[ipus_pkg::COORD_W-1] || py[ipus_pkg::COORD_W-1] ||
                   (px >= ipus_pkg::COORD_W'(ipus_pkg::FRAME_WIDTH)) ||
                   (py >= ipus_pkg::COORD_W'(ipus_pkg::FRAME_HEIGHT));

  assign rd_addr = {py[ipus_pkg::ROW_W-1:0], px[ipus_pkg::COL_W-1:0]};

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) frame_store[head.addr] <= head.data;
    if (mem_re) rd_data <= frame_store[rd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      sample_value  <= outside ? ipus_pkg::OUTSIDE_VALUE : rd_data;
      outside_frame <= outside;
      mapped_col    <= sat_map(px);
      mapped_row    <= sat_map(py);
    end
  end

  assign empty         = !out_valid;
  assign stat.busy     = (state != ipus_pkg::ST_IDLE);
  assign stat.res_load = res_load;

endmodule
